FILE: hdl/chacha20_stream_xor_top_assert.svh
// Assertion macros for the stream cipher top level.
`ifndef CHACHA20_STREAM_XOR_TOP_ASSERT_SVH
`define CHACHA20_STREAM_XOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/chacha_pkg.sv
`default_nettype none

package chacha_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  localparam word_t Sigma0 = 32'h6170_7865;
  localparam word_t Sigma1 = 32'h3320_646e;
  localparam word_t Sigma2 = 32'h7962_2d32;
  localparam word_t Sigma3 = 32'h6b20_6574;

  localparam int RotA = 16;
  localparam int RotB = 12;
  localparam int RotC = 8;
  localparam int RotD = 7;

  localparam int NumDoubleRounds = 10;
  localparam int NumWords        = 16;
  localparam int BlockBytes      = 64;
  localparam int PosWidth        = $clog2(BlockBytes);

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 64;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_KEY01    = 3'd0,
    REG_KEY23    = 3'd1,
    REG_KEY45    = 3'd2,
    REG_KEY67    = 3'd3,
    REG_INIT_CTR = 3'd4,
    REG_NONCE01  = 3'd5,
    REG_NONCE2   = 3'd6
  } cfg_reg_e;

endpackage

`default_nettype wire

FILE: hdl/chacha20_stream_xor_top.sv
// Restart request: taken while idle; it gives no result. Keystream held: the request
// moves to the emit state, which registers the result; new requests stall until idle.
// No keystream held: the request goes through the round, feed-forward and emit states
// in that order; the single half-quarter-round unit does all of the round steps.
// Reset (rst, synchronous, active high) clears control, counter and config registers
// and stalls requests; the held keystream words are not cleared.
`default_nettype none

`include "chacha20_stream_xor_top_assert.svh"

module chacha20_stream_xor_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  chacha_pkg::item_t                    item,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output chacha_pkg::result_t                  result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [chacha_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [chacha_pkg::CfgDataWidth-1:0]  cfg_data
);
  import chacha_pkg::*;

  localparam int StepCount = NumDoubleRounds * 16;
  localparam int StepWidth = $clog2(StepCount);
  localparam int FfWidth   = $clog2(NumWords);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_FINAL,
    S_EMIT
  } state_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } quad_t;

  function automatic word_t rotl(word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // one half of a quarter round; second half uses the 8/7 rotations
  function automatic quad_t qr_half(quad_t q, logic second);
    quad_t r;
    word_t t;
    r   = q;
    r.a = q.a + q.b;
    t   = q.d ^ r.a;
    r.d = second ? rotl(t, RotC) : rotl(t, RotA);
    r.c = q.c + r.d;
    t   = q.b ^ r.c;
    r.b = second ? rotl(t, RotD) : rotl(t, RotB);
    return r;
  endfunction

  state_t                 state;
  logic [StepWidth-1:0]   step;
  logic [FfWidth-1:0]     ff_cnt;
  logic [PosWidth-1:0]    pos;
  logic                   ks_valid;
  word_t                  block_counter;
  logic [7:0]             cur_byte;
  logic                   cur_eom;

  logic [63:0]            key01;
  logic [63:0]            key23;
  logic [63:0]            key45;
  logic [63:0]            key67;
  word_t                  init_ctr;
  logic [63:0]            nonce01;
  word_t                  nonce2;

  word_t                  w      [NumWords];
  word_t                  ks     [NumWords];
  word_t                  init_w [NumWords];
  word_t                  upd    [NumWords];
  word_t                  rot    [NumWords];
  word_t                  w_round[NumWords];
  quad_t                  q;
  word_t                  ks_word;
  logic [7:0]             ks_byte;

  always_comb begin
    init_w[0]  = Sigma0;
    init_w[1]  = Sigma1;
    init_w[2]  = Sigma2;
    init_w[3]  = Sigma3;
    init_w[4]  = key01[31:0];
    init_w[5]  = key01[63:32];
    init_w[6]  = key23[31:0];
    init_w[7]  = key23[63:32];
    init_w[8]  = key45[31:0];
    init_w[9]  = key45[63:32];
    init_w[10] = key67[31:0];
    init_w[11] = key67[63:32];
    init_w[12] = block_counter;
    init_w[13] = nonce01[31:0];
    init_w[14] = nonce01[63:32];
    init_w[15] = nonce2;
  end

  // state kept as 4 rows of 4; the unit always works on column 0 and rows rotate
  always_comb begin
    q = qr_half({w[0], w[4], w[8], w[12]}, step[0]);
    for (int i = 0; i < NumWords; i++) begin
      upd[i] = w[i];
    end
    upd[0]  = q.a;
    upd[4]  = q.b;
    upd[8]  = q.c;
    upd[12] = q.d;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        rot[r*4+j] = upd[r*4+((j+1)%4)];
      end
    end
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        if (!step[0]) begin
          w_round[r*4+j] = upd[r*4+j];
        end else if (step[2:1] != 2'd3) begin
          w_round[r*4+j] = rot[r*4+j];
        end else if (!step[3]) begin
          w_round[r*4+j] = rot[r*4+((j+r)%4)];      // diagonalise
        end else begin
          w_round[r*4+j] = rot[r*4+((j+4-r)%4)];    // back to columns
        end
      end
    end
  end

  assign ks_word    = ks[pos[PosWidth-1:2]];
  assign ks_byte    = ks_word[8*pos[1:0] +: 8];
  assign item_stall = rst || (state != S_IDLE);
  assign cfg_ready  = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= '0;
      ff_cnt        <= '0;
      pos           <= '0;
      ks_valid      <= 1'b0;
      block_counter <= '0;
      result_valid  <= 1'b0;
      key01         <= '0;
      key23         <= '0;
      key45         <= '0;
      key67         <= '0;
      init_ctr      <= '0;
      nonce01       <= '0;
      nonce2        <= '0;
    end else begin
      if (result_valid && !result_stall && state != S_EMIT) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_KEY01:    key01    <= cfg_data;
          REG_KEY23:    key23    <= cfg_data;
          REG_KEY45:    key45    <= cfg_data;
          REG_KEY67:    key67    <= cfg_data;
          REG_INIT_CTR: init_ctr <= cfg_data[31:0];
          REG_NONCE01:  nonce01  <= cfg_data;
          REG_NONCE2:   nonce2   <= cfg_data[31:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur_byte <= item.data_byte;
            cur_eom  <= item.end_of_message;
            if (item.kind) begin
              block_counter <= init_ctr;
              ks_valid      <= 1'b0;
              pos           <= '0;
            end else if (ks_valid) begin
              state <= S_EMIT;
            end else begin
              for (int i = 0; i < NumWords; i++) begin
                w[i] <= init_w[i];
              end
              step  <= '0;
              state <= S_ROUND;
            end
          end
        end
        S_ROUND: begin
          for (int i = 0; i < NumWords; i++) begin
            w[i] <= w_round[i];
          end
          step <= step + 1'b1;
          if (step == StepWidth'(StepCount - 1)) begin
            ff_cnt <= '0;
            state  <= S_FINAL;
          end
        end
        S_FINAL: begin
          for (int i = 0; i < NumWords - 1; i++) begin
            ks[i] <= ks[i+1];
            w[i]  <= w[i+1];
          end
          ks[NumWords-1] <= w[0] + init_w[ff_cnt];
          ff_cnt         <= ff_cnt + 1'b1;
          if (ff_cnt == FfWidth'(NumWords - 1)) begin
            block_counter <= block_counter + 32'd1;
            ks_valid      <= 1'b1;
            pos           <= '0;
            state         <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!result_valid || !result_stall) begin
            result_valid    <= 1'b1;
            result.out_byte <= cur_byte ^ ks_byte;
            result.last     <= cur_eom;
            if (pos == PosWidth'(BlockBytes - 1) || cur_eom) begin
              ks_valid <= 1'b0;
              pos      <= '0;
            end else begin
              pos <= pos + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CS_ASSERT_NOW(a_no_ks_while_busy, state == S_ROUND || state == S_FINAL, !ks_valid, "keystream held during block generation")
  `CS_ASSERT_NEXT(a_round_to_final, state == S_ROUND && step == StepWidth'(StepCount - 1), state == S_FINAL && ff_cnt == '0, "rounds did not hand over to feed-forward")
  `CS_ASSERT_NEXT(a_final_done, state == S_FINAL && ff_cnt == FfWidth'(NumWords - 1), state == S_EMIT && ks_valid && pos == '0, "block not marked held after feed-forward")
  `CS_ASSERT_NEXT(a_emit_result, state == S_EMIT && !(result_valid && result_stall), result_valid && state == S_IDLE, "result not issued from emit")

endmodule

`default_nettype wire

FILE: test/chacha20_stream_xor_top_test.sv
`timescale 1ns / 1ps

module chacha20_stream_xor_top_test;
  import chacha_pkg::*;

  localparam logic KindData    = 1'b0;
  localparam logic KindRestart = 1'b1;
  localparam logic [CfgIndexWidth-1:0] RegUnused = 3'd7;

  localparam int CycleLimit   = 2000000;
  localparam int LongHold     = 600;
  localparam int RandomPhases = 7;
  localparam int PhaseItems   = 200;

  typedef enum int {StallNone, StallLight, StallHeavy, StallPattern} stall_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     item_valid = 1'b0;
  logic                     item_stall;
  item_t                    item = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  result_t                  result;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  chacha20_stream_xor_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // cipher state mirror
  word_t               key_w [8];
  word_t               nonce_w [3];
  word_t               ctr_init;
  word_t               blk_ctr;
  word_t               ks_words [NumWords];
  logic [PosWidth-1:0] ks_pos;
  bit                  ks_held;

  item_t   request_q [$];
  result_t xor_results_q [$];
  int      fail_count = 0;
  int      cycle_count = 0;

  initial begin
    for (int i = 0; i < 8; i++) key_w[i] = '0;
    for (int i = 0; i < 3; i++) nonce_w[i] = '0;
    for (int i = 0; i < NumWords; i++) ks_words[i] = '0;
    ctr_init = '0;
    blk_ctr  = '0;
    ks_pos   = '0;
    ks_held  = 1'b0;
  end

  function automatic word_t rotl(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] qround(word_t a, word_t b, word_t c, word_t d);
    a += b; d = rotl(d ^ a, RotA);
    c += d; b = rotl(b ^ c, RotB);
    a += b; d = rotl(d ^ a, RotC);
    c += d; b = rotl(b ^ c, RotD);
    return {a, b, c, d};
  endfunction

  function automatic void make_keystream();
    word_t init_w [NumWords];
    word_t w [NumWords];
    int    ib, ic, id;
    init_w[0] = Sigma0;
    init_w[1] = Sigma1;
    init_w[2] = Sigma2;
    init_w[3] = Sigma3;
    for (int i = 0; i < 8; i++) init_w[4 + i] = key_w[i];
    init_w[12] = blk_ctr;
    for (int i = 0; i < 3; i++) init_w[13 + i] = nonce_w[i];
    w = init_w;
    for (int r = 0; r < NumDoubleRounds; r++) begin
      for (int i = 0; i < 4; i++) begin
        {w[i], w[i + 4], w[i + 8], w[i + 12]} = qround(w[i], w[i + 4], w[i + 8], w[i + 12]);
      end
      for (int i = 0; i < 4; i++) begin
        ib = 4 + (i + 1) % 4;
        ic = 8 + (i + 2) % 4;
        id = 12 + (i + 3) % 4;
        {w[i], w[ib], w[ic], w[id]} = qround(w[i], w[ib], w[ic], w[id]);
      end
    end
    for (int i = 0; i < NumWords; i++) ks_words[i] = w[i] + init_w[i];
    blk_ctr = blk_ctr + 1;
  endfunction

  function automatic void chacha_predict(item_t req);
    logic [7:0] ks;
    if (req.kind == KindRestart) begin
      blk_ctr = ctr_init;
      ks_held = 1'b0;
      ks_pos  = '0;
    end else begin
      if (!ks_held) begin
        make_keystream();
        ks_held = 1'b1;
        ks_pos  = '0;
      end
      ks = ks_words[ks_pos[5:2]][{ks_pos[1:0], 3'b000} +: 8];
      xor_results_q.push_back('{out_byte: req.data_byte ^ ks, last: req.end_of_message});
      ks_pos = ks_pos + 1'b1;
      if (ks_pos == '0 || req.end_of_message) begin
        ks_held = 1'b0;
        ks_pos  = '0;
      end
    end
  endfunction

  function automatic void apply_cfg(logic [CfgIndexWidth-1:0] idx, logic [63:0] v);
    case (idx)
      REG_KEY01: begin
        key_w[0] = v[31:0];
        key_w[1] = v[63:32];
      end
      REG_KEY23: begin
        key_w[2] = v[31:0];
        key_w[3] = v[63:32];
      end
      REG_KEY45: begin
        key_w[4] = v[31:0];
        key_w[5] = v[63:32];
      end
      REG_KEY67: begin
        key_w[6] = v[31:0];
        key_w[7] = v[63:32];
      end
      REG_INIT_CTR: ctr_init = v[31:0];
      REG_NONCE01: begin
        nonce_w[0] = v[31:0];
        nonce_w[1] = v[63:32];
      end
      REG_NONCE2: nonce_w[2] = v[31:0];
      default: ;
    endcase
  endfunction

  function automatic void queue_request(logic kind, logic [7:0] b, logic eom);
    request_q.push_back('{kind: kind, data_byte: b, end_of_message: eom});
  endfunction

  function automatic logic [63:0] pick_cfg_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return '0;
      1: return '1;
      2: return {$urandom, 32'hFFFF_FFF0 | 32'($urandom_range(0, 15))};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic cfg_write(logic [CfgIndexWidth-1:0] idx, logic [63:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, v);
    cfg_valid <= 1'b0;
  endtask

  // wait for the sender to run dry and every result to arrive
  task automatic drain(int extra);
    while (request_q.size() != 0 || item_valid || xor_results_q.size() != 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive_proc
    bit    took;
    bit    nv;
    item_t nxt;
    took = item_valid && !item_stall;
    nv   = 1'b0;
    nxt  = item;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (took) begin
        chacha_predict(item);
        void'(request_q.pop_front());
      end
      if (item_valid && !took) begin
        nv = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (request_q.size() > 0) begin
        nv  = 1'b1;
        nxt = request_q[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
      item_valid <= nv;
      item       <= nxt;
    end
  end

  // receiver: stall pattern, plus a long hold every so often
  stall_mode_e stall_mode = StallNone;
  int          mode_left = 0;
  int          hold_left = 0;
  int          hold_at = 250;
  int          rx_count = 0;
  int          pat_phase = 0;

  always @(posedge clk) begin : stall_proc
    bit s;
    s = 1'b0;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) rx_count++;
      if (hold_left == 0 && rx_count >= hold_at) begin
        hold_left = LongHold;
        hold_at += 550;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      pat_phase = (pat_phase + 1) % 7;
      if (hold_left > 0) begin
        hold_left--;
        s = 1'b1;
      end else begin
        case (stall_mode)
          StallNone:  s = 1'b0;
          StallLight: s = ($urandom_range(0, 3) == 0);
          StallHeavy: s = ($urandom_range(0, 3) != 0);
          default:    s = (pat_phase < 3);
        endcase
      end
      result_stall <= s;
    end
  end

  always @(posedge clk) begin : check_proc
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (xor_results_q.size() == 0) begin
        $display("%0t: unexpected result: out_byte=%02h last=%0b",
                 $time, result.out_byte, result.last);
        fail_count++;
      end else begin
        want = xor_results_q.pop_front();
        if (result.out_byte !== want.out_byte || result.last !== want.last) begin
          $display("%0t: mismatch: expected out_byte=%02h last=%0b, got out_byte=%02h last=%0b",
                   $time, want.out_byte, want.last, result.out_byte, result.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog_proc
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int  n;
    int  len;
    int  sel;
    bit  abandon;
    bit  close;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: byte extremes, end of message, restarts
    queue_request(KindData, 8'h00, 1'b0);
    queue_request(KindData, 8'hFF, 1'b0);
    queue_request(KindData, 8'hA5, 1'b1);
    queue_request(KindRestart, 8'hFF, 1'b1);
    queue_request(KindData, 8'h5A, 1'b0);
    queue_request(KindRestart, 8'h00, 1'b0);
    queue_request(KindData, 8'hFF, 1'b1);
    drain(8);

    // all ones, counter about to wrap
    for (int i = REG_KEY01; i <= REG_NONCE2; i++) cfg_write(CfgIndexWidth'(i), '1);
    queue_request(KindRestart, 8'h00, 1'b0);
    queue_request(KindData, 8'h00, 1'b1);
    queue_request(KindData, 8'hFF, 1'b1);
    queue_request(KindData, 8'h3C, 1'b0);
    drain(8);

    // rewrite while a block is held; the held block must stay in use
    cfg_write(REG_NONCE2, '0);
    cfg_write(REG_KEY01, 64'h0123_4567_89AB_CDEF);
    cfg_write(RegUnused, {$urandom, $urandom});
    queue_request(KindData, 8'hC3, 1'b0);
    queue_request(KindData, 8'h81, 1'b1);
    drain(8);

    // standard test key and nonce, counter one
    cfg_write(REG_KEY01, 64'h0706_0504_0302_0100);
    cfg_write(REG_KEY23, 64'h0F0E_0D0C_0B0A_0908);
    cfg_write(REG_KEY45, 64'h1716_1514_1312_1110);
    cfg_write(REG_KEY67, 64'h1F1E_1D1C_1B1A_1918);
    cfg_write(REG_INIT_CTR, 64'h1);
    cfg_write(REG_NONCE01, 64'h4A00_0000_0900_0000);
    cfg_write(REG_NONCE2, 64'h0);
    queue_request(KindRestart, 8'h00, 1'b0);
    for (int j = 0; j < 6; j++) queue_request(KindData, 8'h00, j == 5);
    drain(8);

    for (int p = 0; p < RandomPhases; p++) begin
      for (int i = REG_KEY01; i <= REG_NONCE2; i++) begin
        if (p == 0 || $urandom_range(0, 1) == 0)
          cfg_write(CfgIndexWidth'(i), pick_cfg_value());
      end
      n = 0;
      if ($urandom_range(0, 1) == 0) begin
        queue_request(KindRestart, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        n++;
      end
      while (n < PhaseItems) begin
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
          queue_request(KindRestart, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          n++;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(1, 20);
            6, 7:             len = $urandom_range(21, 64);
            8:                len = $urandom_range(63, 65);
            default:          len = $urandom_range(66, 200);
          endcase
          abandon = (sel < 12);
          close   = !abandon && ($urandom_range(0, 7) != 0);
          for (int j = 0; j < len; j++)
            queue_request(KindData, 8'($urandom_range(0, 255)), close && (j == len - 1));
          n += len;
          if (abandon) begin
            queue_request(KindRestart, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            n++;
          end
        end
      end
      drain(8);
    end

    drain(200);
    if (fail_count == 0 && xor_results_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/chacha_pkg.sv
hdl/chacha20_stream_xor_top.sv
test/chacha20_stream_xor_top_test.sv
